// File: rtl/core/bounded_positional_list_macros.svh
// Assertion helpers for the list engine.
`ifndef BOUNDED_POSITIONAL_LIST_MACROS_SVH
`define BOUNDED_POSITIONAL_LIST_MACROS_SVH

// Checked outside reset.
`define BLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define BLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/blp_pkg.sv
package blp_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 8;
  localparam int POS_W     = 7;
  localparam int CNT_OUT_W = 7;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value_in;
  } blp_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] count_out;
    logic [VAL_W-1:0]     value_out;
  } blp_out_t;

  typedef enum logic {
    BLP_IDLE,
    BLP_READ
  } blp_state_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_LOAD,
    CMD_SHIFT
  } blp_cmd_t;

  typedef struct packed {
    blp_cmd_t         cmd;
    logic [VAL_W-1:0] data;
  } blp_ctl_t;

endpackage

// File: rtl/core/blp_cell.sv
// One list slot plus one read-tap stage.
module blp_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  logic                      clk,
  input  blp_pkg::blp_ctl_t         ctl,
  input  logic [IDX_W-1:0]          idx,
  input  logic [blp_pkg::VAL_W-1:0] left_val,
  input  logic [blp_pkg::VAL_W-1:0] right_val,
  input  logic [blp_pkg::VAL_W-1:0] right_tap,
  output logic [blp_pkg::VAL_W-1:0] val,
  output logic [blp_pkg::VAL_W-1:0] tap
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [blp_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [blp_pkg::VAL_W-1:0] tap_r, tap_nxt;

  always_comb begin
    val_nxt = val_r;
    tap_nxt = tap_r;
    case (ctl.cmd)
      blp_pkg::CMD_INSERT: begin
        if (MY_IDX == idx) begin
          val_nxt = ctl.data;
        end else if (MY_IDX > idx) begin
          val_nxt = left_val;
        end
      end
      blp_pkg::CMD_DELETE: begin
        if (MY_IDX >= idx) begin
          val_nxt = right_val;
        end
      end
      blp_pkg::CMD_LOAD:  tap_nxt = val_r;
      blp_pkg::CMD_SHIFT: tap_nxt = right_tap;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    tap_r <= tap_nxt;
  end

  assign val = val_r;
  assign tap = tap_r;

endmodule

// File: rtl/core/blp_chain.sv
// Row of cells; slot 0 is list position 1. Taps shift toward the head.
module blp_chain #(
  parameter int DEPTH = blp_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  blp_pkg::blp_ctl_t         ctl,
  input  logic [IDX_W-1:0]          idx,
  output logic [blp_pkg::VAL_W-1:0] head_tap
);

  logic [blp_pkg::VAL_W-1:0] val_w [DEPTH];
  logic [blp_pkg::VAL_W-1:0] tap_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [blp_pkg::VAL_W-1:0] left_v, right_v, right_t;

    if (i == 0) begin : g_head
      assign left_v = ctl.data;
    end else begin : g_mid_l
      assign left_v = val_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_v = '0;
      assign right_t = '0;
    end else begin : g_mid_r
      assign right_v = val_w[i+1];
      assign right_t = tap_w[i+1];
    end

    blp_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (idx),
      .left_val  (left_v),
      .right_val (right_v),
      .right_tap (right_t),
      .val       (val_w[i]),
      .tap       (tap_w[i])
    );
  end

  assign head_tap = tap_w[0];

endmodule

// File: rtl/core/bounded_positional_list.sv
// Channel   | Ports                       | Transfer
// ----------+-----------------------------+----------------------------------
// input     | start, busy, in_item        | clk edge with start=1, busy=0
// result    | out_strobe, out_item        | clk edge ending the strobe cycle
//
// Insert, delete and any failed operation: result strobes in the cycle after
// the transfer, and busy stays low, so a new item may follow at once.
// Successful read at position p: the slots load into the tap row, which walks
// toward the head while busy is high; the result strobes once slot p-1's tap is at the head.
// Reset (rst_n low, synchronous) clears the count, state and strobe; list
// slots hold whatever they held. The receiver cannot stall: a result is
// shown for exactly one cycle.
module bounded_positional_list #(
  parameter int DEPTH = blp_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  blp_pkg::blp_in_t  in_item,
  output logic              out_strobe,
  output blp_pkg::blp_out_t out_item
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // wide enough for count+1 and for a raw position
  localparam int CMP_W = ((CNT_W > blp_pkg::POS_W) ? CNT_W : blp_pkg::POS_W) + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  blp_pkg::blp_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    remain_r, remain_nxt;
  logic                strobe_r, strobe_nxt;
  blp_pkg::blp_out_t   res_r, res_nxt;

  blp_pkg::blp_ctl_t         ctl;
  logic [IDX_W-1:0]          chain_idx;
  logic [blp_pkg::VAL_W-1:0] head_tap;

  // decode of the offered item against the current count
  logic             accept;
  logic [CMP_W-1:0] pos_ext, cnt_ext, pos_m1;
  logic             pos_nz, ins_in_range, in_range, full;
  logic             is_ins, is_del, is_rd;
  logic             ins_go, del_go, rd_go;

  assign busy    = (state_r == blp_pkg::BLP_READ);
  assign accept  = start && !busy;

  assign pos_ext = CMP_W'(in_item.position);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_m1  = pos_ext - CMP_W'(1);
  assign pos_nz  = (pos_ext != '0);
  assign ins_in_range = pos_nz && (pos_ext <= cnt_ext + CMP_W'(1));
  assign in_range     = pos_nz && (pos_ext <= cnt_ext);
  assign full    = (count_r == FULL_CNT);

  assign is_ins  = (in_item.action == blp_pkg::ACT_INSERT);
  assign is_del  = (in_item.action == blp_pkg::ACT_DELETE);
  assign is_rd   = (in_item.action == blp_pkg::ACT_READ);

  assign ins_go  = accept && is_ins && ins_in_range && !full;
  assign del_go  = accept && is_del && in_range;
  assign rd_go   = accept && is_rd && in_range;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      blp_pkg::BLP_IDLE: begin
        if (rd_go) begin
          state_nxt = blp_pkg::BLP_READ;
        end
      end
      blp_pkg::BLP_READ: begin
        if (remain_r == '0) begin
          state_nxt = blp_pkg::BLP_IDLE;
        end
      end
      default: state_nxt = blp_pkg::BLP_IDLE;
    endcase
  end

  // outputs: cell commands, count update, result
  always_comb begin
    ctl.cmd    = blp_pkg::CMD_HOLD;
    ctl.data   = in_item.value_in;
    chain_idx  = IDX_W'(pos_m1);
    count_nxt  = count_r;
    remain_nxt = remain_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    case (state_r)
      blp_pkg::BLP_IDLE: begin
        if (accept) begin
          res_nxt.value_out = '0;
          res_nxt.status    = blp_pkg::ST_OK;
          if (ins_go) begin
            ctl.cmd   = blp_pkg::CMD_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end else if (del_go) begin
            ctl.cmd   = blp_pkg::CMD_DELETE;
            count_nxt = count_r - CNT_W'(1);
          end else if (rd_go) begin
            // snapshot the slots into the taps, then walk idx places
            ctl.cmd    = blp_pkg::CMD_LOAD;
            remain_nxt = IDX_W'(pos_m1);
          end else if (is_ins && ins_in_range) begin
            res_nxt.status = blp_pkg::ST_FULL;
          end else begin
            res_nxt.status = blp_pkg::ST_BADPOS;
          end
          res_nxt.count_out = blp_pkg::CNT_OUT_W'(count_nxt);
          strobe_nxt        = !rd_go;
        end
      end
      blp_pkg::BLP_READ: begin
        if (remain_r == '0) begin
          res_nxt.status    = blp_pkg::ST_OK;
          res_nxt.count_out = blp_pkg::CNT_OUT_W'(count_r);
          res_nxt.value_out = head_tap;
          strobe_nxt        = 1'b1;
        end else begin
          ctl.cmd    = blp_pkg::CMD_SHIFT;
          remain_nxt = remain_r - IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= blp_pkg::BLP_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remain_r <= remain_nxt;
    res_r    <= res_nxt;
  end

  blp_chain #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .idx      (chain_idx),
    .head_tap (head_tap)
  );

  assign out_strobe = strobe_r;
  assign out_item   = res_r;

endmodule

// File: rtl/core/blp_checker.sv
`include "bounded_positional_list_macros.svh"

module blp_checker #(
  parameter int DEPTH = blp_pkg::DEPTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input blp_pkg::blp_in_t  in_item,
  input logic              out_strobe,
  input blp_pkg::blp_out_t out_item
);

  `BLP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe && !busy, "strobe or busy after reset")

  `BLP_ASSERT(a_quick_result, start && !busy && (in_item.action != blp_pkg::ACT_READ) |=> out_strobe, "non-read transfer gave no result next cycle")

  `BLP_ASSERT(a_fail_zero, out_strobe && (out_item.status != blp_pkg::ST_OK) |-> out_item.value_out == '0, "failed operation returned data")

  `BLP_ASSERT(a_full_count, out_strobe && (out_item.status == blp_pkg::ST_FULL) |-> int'(out_item.count_out) == DEPTH, "full status with list not full")

  `BLP_ASSERT(a_count_bound, out_strobe |-> int'(out_item.count_out) <= DEPTH, "count beyond depth")

endmodule

bind bounded_positional_list blp_checker #(.DEPTH(DEPTH)) u_blp_checker (.*);
